// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/u128alu_pkg.sv
package u128alu_pkg;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_REM = 3'd4,
        MODE_CMP = 3'd5
    } alu_mode_t;

    localparam int DIV_STEP_BITS  = 8;
    localparam int NUM_STAGES     = 128 / DIV_STEP_BITS;
    localparam int MUL_DONE_STAGE = 2;
    localparam logic [31:0] DIVISOR_MASK = 32'hFFFFFFFF;

    typedef struct packed {
        logic         valid;
        alu_mode_t    mode;
        logic [127:0] num;
        logic [31:0]  rem;
        logic [31:0]  dvs;
        logic [127:0] arith;
        logic         less;
        logic         equal;
        logic         derr;
    } stage_t;

endpackage

// File: rtl/u128_integer_alu.sv
// 128-bit unsigned ALU: add, subtract, low half of multiply, divide and remainder by a
// 32-bit divisor, and compare. Every item passes through the input register and then the
// pipeline stages; one item may enter on every clock while in_stall is low. The depth is set
// by the divider, which retires 8 quotient bits per stage over 128 bits; the
// multiply finishes in the first three stages and rides along. out_stall freezes the
// whole pipeline, so in_stall follows it whenever the output holds a result.
`include "assert_macros.svh"

module u128_integer_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [63:0] a_high,
    input  logic [63:0] a_low,
    input  logic [63:0] b_high,
    input  logic [63:0] b_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    output logic        is_less,
    output logic        is_equal,
    output logic        divide_error
);
    import u128alu_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    logic         en;
    logic         in0_valid_reg;
    alu_mode_t    in0_mode_reg;
    logic [127:0] in0_a_reg;
    logic [127:0] in0_b_reg;

    stage_t pipe_reg  [NUM_STAGES];
    stage_t pipe_next [NUM_STAGES];
    stage_t src_w     [NUM_STAGES];
    stage_t base_w;

    logic [63:0]  pp_reg  [10];
    logic [63:0]  pp_next [10];
    logic [63:0]  col0_reg, col0_next;
    logic [64:0]  col1_reg, col1_next;
    logic [65:0]  col2_reg, col2_next;
    logic [31:0]  col3_reg, col3_next;
    logic [127:0] prod_w;

    function automatic logic [159:0] div_step(input logic [127:0] num_in,
                                              input logic [31:0] rem_in,
                                              input logic [31:0] dvs_in);
        logic [127:0] n;
        logic [31:0]  r;
        logic [32:0]  t;
        logic [32:0]  d;
        n = num_in;
        r = rem_in;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            t = {r, n[127]};
            d = t - {1'b0, dvs_in};
            if (t >= {1'b0, dvs_in}) begin
                r = d[31:0];
                n = {n[126:0], 1'b1};
            end else begin
                r = t[31:0];
                n = {n[126:0], 1'b0};
            end
        end
        return {n, r};
    endfunction

    // The whole pipeline advances together unless a finished result is held back.
    assign en       = !pipe_reg[LAST].valid || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in0_mode_reg <= alu_mode_t'(mode);
            in0_a_reg    <= {a_high, a_low};
            in0_b_reg    <= {b_high, b_low};
        end
    end

    // First stage: add, subtract and compare in full, divider set up.
    always_comb
    begin
        logic [127:0] sum;
        logic [127:0] diff;
        sum  = in0_a_reg + in0_b_reg;
        diff = in0_a_reg - in0_b_reg;
        base_w.valid = in0_valid_reg;
        base_w.mode  = in0_mode_reg;
        base_w.num   = in0_a_reg;
        base_w.rem   = '0;
        base_w.dvs   = in0_b_reg[31:0] & DIVISOR_MASK;
        base_w.arith = '0;
        base_w.less  = 1'b0;
        base_w.equal = 1'b0;
        base_w.derr  = 1'b0;
        case (in0_mode_reg)
            MODE_ADD: base_w.arith = sum;
            MODE_SUB: base_w.arith = diff;
            MODE_CMP:
            begin
                base_w.less  = in0_a_reg < in0_b_reg;
                base_w.equal = in0_a_reg == in0_b_reg;
            end
            default: base_w.arith = '0;
        endcase
    end

    // Partial products of 32-bit digits whose weight stays below 2^128.
    always_comb
    begin
        pp_next[0] = in0_a_reg[31:0]  * in0_b_reg[31:0];
        pp_next[1] = in0_a_reg[31:0]  * in0_b_reg[63:32];
        pp_next[2] = in0_a_reg[63:32] * in0_b_reg[31:0];
        pp_next[3] = in0_a_reg[31:0]  * in0_b_reg[95:64];
        pp_next[4] = in0_a_reg[63:32] * in0_b_reg[63:32];
        pp_next[5] = in0_a_reg[95:64] * in0_b_reg[31:0];
        pp_next[6] = in0_a_reg[31:0]  * in0_b_reg[127:96];
        pp_next[7] = in0_a_reg[63:32] * in0_b_reg[95:64];
        pp_next[8] = in0_a_reg[95:64] * in0_b_reg[63:32];
        pp_next[9] = in0_a_reg[127:96] * in0_b_reg[31:0];
    end

    always_comb
    begin
        logic [31:0] c3;
        c3 = pp_reg[6][31:0] + pp_reg[7][31:0] + pp_reg[8][31:0] + pp_reg[9][31:0];
        col0_next = pp_reg[0];
        col1_next = {1'b0, pp_reg[1]} + {1'b0, pp_reg[2]};
        col2_next = {2'b00, pp_reg[3]} + {2'b00, pp_reg[4]} + {2'b00, pp_reg[5]};
        col3_next = c3;
    end

    assign prod_w = {64'd0, col0_reg} + {31'd0, col1_reg, 32'd0}
                  + {col2_reg[63:0], 64'd0} + {col3_reg, 96'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            col0_reg <= col0_next;
            col1_reg <= col1_next;
            col2_reg <= col2_next;
            col3_reg <= col3_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_STAGES; g++)
        begin : g_stage
            if (g == 0)
            begin : g_first
                assign src_w[g] = base_w;
            end
            else
            begin : g_rest
                assign src_w[g] = pipe_reg[g-1];
            end

            always_comb
            begin
                logic [159:0] st;
                st = div_step(src_w[g].num, src_w[g].rem, src_w[g].dvs);
                pipe_next[g]     = src_w[g];
                pipe_next[g].num = st[159:32];
                pipe_next[g].rem = st[31:0];
                if (g == MUL_DONE_STAGE && src_w[g].mode == MODE_MUL)
                begin
                    pipe_next[g].arith = prod_w;
                end
                if (g == LAST && (src_w[g].mode == MODE_DIV || src_w[g].mode == MODE_REM))
                begin
                    if (src_w[g].dvs == '0)
                    begin
                        pipe_next[g].arith = '0;
                        pipe_next[g].derr  = 1'b1;
                    end
                    else if (src_w[g].mode == MODE_DIV)
                    begin
                        pipe_next[g].arith = st[159:32];
                    end
                    else
                    begin
                        pipe_next[g].arith = {96'd0, st[31:0]};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pipe_reg[g].valid <= 1'b0;
                end
                else if (en)
                begin
                    pipe_reg[g] <= pipe_next[g];
                end
            end
        end
    endgenerate

    assign out_valid    = pipe_reg[LAST].valid;
    assign result_high  = pipe_reg[LAST].arith[127:64];
    assign result_low   = pipe_reg[LAST].arith[63:0];
    assign is_less      = pipe_reg[LAST].less;
    assign is_equal     = pipe_reg[LAST].equal;
    assign divide_error = pipe_reg[LAST].derr;

    `ASSERT_IMPLY(a_flags_cmp, out_valid && (is_less || is_equal), pipe_reg[LAST].mode == MODE_CMP)
    `ASSERT_IMPLY(a_derr_zero, out_valid && divide_error, result_high == '0 && result_low == '0)
    `ASSERT_IMPLY(a_rem_narrow, out_valid && pipe_reg[LAST].mode == MODE_REM, result_high == '0)
    `ASSERT_IMPLY(a_cmp_excl, out_valid, !(is_less && is_equal))
    `ASSERT_NEXT(a_hold_full, out_valid && out_stall, out_valid && $stable({result_high, result_low}))

endmodule

// File: tb/sv/u128_alu_checker.sv
`timescale 1ns / 100ps

module u128_alu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [63:0] a_high,
    input  logic [63:0] a_low,
    input  logic [63:0] b_high,
    input  logic [63:0] b_low,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] result_high,
    input  logic [63:0] result_low,
    input  logic        is_less,
    input  logic        is_equal,
    input  logic        divide_error,
    output int          fail_count,
    output int          pending_count
);
    import u128alu_pkg::*;

    typedef struct packed {
        logic [127:0] value;
        logic         less;
        logic         equal;
        logic         derr;
    } alu_answer_t;

    alu_answer_t answers_due[$];

    function automatic alu_answer_t compute_answer(logic [2:0] op, logic [127:0] a,
                                                   logic [127:0] b);
        alu_answer_t ans;
        logic [31:0] divisor;
        ans = '0;
        divisor = b[31:0] & DIVISOR_MASK;
        case (op)
            MODE_ADD: ans.value = a + b;
            MODE_SUB: ans.value = a - b;
            MODE_MUL: ans.value = a * b;
            MODE_DIV, MODE_REM:
            begin
                if (divisor == 0)
                    ans.derr = 1'b1;
                else if (op == MODE_DIV)
                    ans.value = a / {96'd0, divisor};
                else
                    ans.value = a % {96'd0, divisor};
            end
            MODE_CMP:
            begin
                ans.less = a < b;
                ans.equal = a == b;
            end
            default: ans = '0;
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin
        alu_answer_t want;
        alu_answer_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                answers_due.push_back(compute_answer(mode, {a_high, a_low}, {b_high, b_low}));
            if (out_valid && !out_stall)
            begin
                got = {result_high, result_low, is_less, is_equal, divide_error};
                if (answers_due.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("Unexpected result transfer: %h", got);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("Mismatch: value exp %h got %h, lt %b/%b eq %b/%b err %b/%b",
                                     want.value, got.value, want.less, got.less,
                                     want.equal, got.equal, want.derr, got.derr);
                    end
                end
            end
        end
        pending_count = answers_due.size();
    end

    initial fail_count = 0;

endmodule

// File: tb/sv/u128_integer_alu_tb.sv
`timescale 1ns / 100ps

module u128_integer_alu_tb;
    import u128alu_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = '0;
    logic [63:0] a_high = '0;
    logic [63:0] a_low = '0;
    logic [63:0] b_high = '0;
    logic [63:0] b_low = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        is_less;
    logic        is_equal;
    logic        divide_error;
    int          fail_count;
    int          pending_count;
    logic        rx_busy_phase = 1'b1;

    always #5 clk = ~clk;

    u128_integer_alu uut (.*);
    u128_alu_checker checker_inst (.*);

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(5, 30);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [63:0] operand_half();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom} >> $urandom_range(0, 63);
            3: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_operation(logic [2:0] op, logic [63:0] ah, logic [63:0] al,
                                  logic [63:0] bh, logic [63:0] bl);
        mode <= op;
        a_high <= ah;
        a_low <= al;
        b_high <= bh;
        b_low <= bl;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Receiver stall pattern: quiet stretches alternate with random stalls.
    always @(negedge clk)
    begin
        int gap;
        if ($urandom_range(0, 199) == 0)
            rx_busy_phase <= ~rx_busy_phase;
        gap = gap_length();
        out_stall <= rx_busy_phase && (gap != 0);
    end

    initial
    begin
        logic [2:0]  op;
        logic [63:0] bl;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_operation(MODE_ADD, '1, '1, '0, 64'd1);
        send_operation(MODE_ADD, '1, '1, '1, '1);
        send_operation(MODE_SUB, '0, '0, '0, 64'd1);
        send_operation(MODE_SUB, 64'd5, 64'd0, 64'd2, 64'd1);
        send_operation(MODE_MUL, '1, '1, '1, '1);
        send_operation(MODE_MUL, 64'd0, '1, 64'd0, '1);
        send_operation(MODE_DIV, '1, '1, '1, 64'hFFFFFFFF_00000000);
        send_operation(MODE_REM, '1, '1, '0, 64'h0);
        send_operation(MODE_DIV, '1, '1, '1, 64'hFFFFFFFF);
        send_operation(MODE_REM, '1, '1, '0, 64'hDEADBEEF_FFFFFFFF);
        send_operation(MODE_DIV, '0, 64'd7, '0, 64'd1);
        send_operation(MODE_REM, 64'd3, 64'd7, '0, 64'd10);
        send_operation(MODE_CMP, '1, '1, '1, '1);
        send_operation(MODE_CMP, 64'd1, 64'd0, 64'd1, 64'd1);
        send_operation(MODE_CMP, 64'd2, 64'd0, 64'd1, '1);
        send_operation(MODE_CMP, 64'd1, '1, 64'd1, '1);
        send_operation(3'd6, '1, '1, '1, '1);
        send_operation(3'd7, '1, '1, '1, '1);

        // Let the pipeline run dry once before the random traffic starts.
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);

        repeat (1950)
        begin
            op = 3'($urandom_range(0, 7));
            bl = operand_half();
            if ((op == MODE_DIV || op == MODE_REM) && $urandom_range(0, 3) == 0)
                bl[31:0] = $urandom_range(1, 255);
            if ((op == MODE_CMP) && $urandom_range(0, 2) == 0)
                send_operation(op, a_high, a_low, a_high, a_low + $urandom_range(0, 1));
            else
                send_operation(op, operand_half(), operand_half(), operand_half(), bl);
            if ($urandom_range(0, 499) == 0)
            begin
                in_valid <= 1'b0;
                while (pending_count != 0)
                    @(negedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
                idle_sender(gap_length());
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/u128alu_pkg.sv
rtl/u128_integer_alu.sv
tb/sv/u128_alu_checker.sv
tb/sv/u128_integer_alu_tb.sv
